[rtl/pipt_pkg.sv]
`timescale 1ns / 1ps

package pipt_pkg;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Widths of the fixed fields.
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 6;
  localparam int CFG_W   = 8;
  localparam int OUT_W   = 8;

  // Query sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL_A,
    S_MUL_B,
    S_DRAIN,
    S_DONE
  } state_t;

  // Per-cycle datapath controls decoded from the sequencer state.
  typedef struct packed {
    logic rd_next;    // present the next edge address to the store
    logic mul_sel_b;  // multiplier takes the second product of the edge
    logic cmp_en;     // product register holds a finished comparison
    logic flag_en;    // capture straddle and side flags of the edge
  } ctl_t;

endpackage

[rtl/point_in_polygon_test_core.sv]
`timescale 1ns / 1ps
// A query walking n = min(edge_count, MAX_EDGES) edges steps through S_FETCH, then S_MUL_A
// and S_MUL_B for each edge, S_DRAIN and S_DONE (S_DONE at once when n is 0); out_tvalid
// rises when S_DONE finds the output free, and no new beat is taken before that. The single
// shared multiplier forms two cross products per edge; loads are taken back to back while idle.
// Reset (rst_n low, synchronous): sequencer idle, edge_count 0, output empty.
// The edge store is not cleared; a slot must be loaded before a query reads it.
module point_in_polygon_test_core #(
  parameter int MAX_EDGES  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // Configuration: edge_count in bits [5:0].
  input  logic                         cfg_tvalid,
  output logic                         cfg_tready,
  input  logic [pipt_pkg::CFG_W-1:0]   cfg_tdata,
  // tdata from bit 0: edge_index, start_x, start_y, end_x, end_y, point_x, point_y, zero pad.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [((pipt_pkg::INDEX_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // tuser: operation.
  input  logic                         in_tuser,
  // tdata from bit 0: inside_res, crossing_count, zero pad.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pipt_pkg::OUT_W-1:0]   out_tdata
);

  import pipt_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int AW  = $clog2(MAX_EDGES);
  localparam int NW  = $clog2(MAX_EDGES + 1);
  localparam int MW  = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int EW  = 4 * CB;

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [COUNT_W-1:0]  edge_count_r;
  logic signed [CB-1:0] px_r, py_r;
  logic [AW-1:0]       idx_r, last_r;
  logic [COUNT_W-1:0]  count_r;
  logic                straddle_r, trivial_r, dy_pos_r;
  logic signed [2*DW-1:0] a_r;
  logic signed [2*DW-1:0] prod;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                in_acc, is_query, load_ok, out_free;
  logic [MW-1:0]       walk_len;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [EW-1:0]       wr_data, rd_data;
  logic signed [CB-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] mul_a, mul_b;
  logic                straddle, trivial, crossed;

  // Input beat decode.
  assign in_acc   = in_tvalid && in_tready;
  assign is_query = (in_tuser == OP_QUERY);
  assign load_ok  = int'(in_tdata[INDEX_W-1:0]) < MAX_EDGES;
  assign wr_addr  = AW'(in_tdata[INDEX_W-1:0]);
  assign wr_data  = in_tdata[INDEX_W +: EW];
  assign out_free = !out_valid_r || out_tready;

  // Number of edges a query walks.
  assign walk_len = (MW'(edge_count_r) < MW'(MAX_EDGES)) ? MW'(edge_count_r)
                                                         : MW'(MAX_EDGES);

  // Edge store.
  assign rd_addr = ctl.rd_next ? idx_r + AW'(1) : idx_r;

  pipt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_acc && !is_query && load_ok),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign sx = rd_data[0*CB +: CB];
  assign sy = rd_data[1*CB +: CB];
  assign ex = rd_data[2*CB +: CB];
  assign ey = rd_data[3*CB +: CB];

  // Edge classification against the query point.
  assign straddle = (sy >= py_r && ey < py_r) || (sy < py_r && ey >= py_r);
  assign trivial  = (sx >= px_r) && (ex >= px_r);

  // Operand select for the shared multiplier: first (py-sy)*(ex-sx), then (px-sx)*dy.
  always_comb begin
    if (ctl.mul_sel_b) begin
      mul_a = DW'(px_r) - DW'(sx);
      mul_b = DW'(ey) - DW'(sy);
    end else begin
      mul_a = DW'(py_r) - DW'(sy);
      mul_b = DW'(ex) - DW'(sx);
    end
  end

  pipt_mul #(
    .W (DW)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Crossing decision for the edge whose products are now complete.
  assign crossed = straddle_r &&
                   (trivial_r || (dy_pos_r ? (a_r >= prod) : (a_r <= prod)));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = (walk_len == '0) ? S_DONE : S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_MUL_A;
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = (idx_r == last_r) ? S_DRAIN : S_MUL_A;
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls per state.
  always_comb begin
    ctl = '0;
    case (state_r)
      S_MUL_A: ctl.cmp_en = 1'b1;
      S_MUL_B: begin
        ctl.rd_next   = 1'b1;
        ctl.mul_sel_b = 1'b1;
        ctl.flag_en   = 1'b1;
      end
      S_DRAIN: ctl.cmp_en = 1'b1;
      default: ctl = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) begin
        edge_count_r <= cfg_tdata[COUNT_W-1:0];
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Query walk registers.
  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      px_r       <= $signed(in_tdata[INDEX_W + 4*CB +: CB]);
      py_r       <= $signed(in_tdata[INDEX_W + 5*CB +: CB]);
      last_r     <= AW'(walk_len - MW'(1));
      idx_r      <= '0;
      count_r    <= '0;
      straddle_r <= 1'b0;
    end else begin
      if (ctl.rd_next) begin
        idx_r <= idx_r + AW'(1);
      end
      if (ctl.cmp_en && crossed) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (ctl.flag_en) begin
        straddle_r <= straddle;
        trivial_r  <= trivial;
        dy_pos_r   <= (ey > sy);
        a_r        <= prod;
      end
    end
  end

  // Result register; the count wraps at 64 but keeps the parity of the full count.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {1'b0, count_r, count_r[0]};
    end
  end

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A query that walks edges always starts with a store fetch.
  a_query_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_QUERY && walk_len != '0)
    |=> state_r == S_FETCH)
    else $error("query did not start its edge walk");

  // The walk never runs past the last edge of the query.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_A || state_r == S_MUL_B) |-> idx_r <= last_r)
    else $error("edge index ran past the walk length");

  // A result appears only out of the finishing state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the finishing state");
`endif

endmodule

[rtl/pipt_ram.sv]
`timescale 1ns / 1ps

module pipt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[rtl/pipt_mul.sv]
`timescale 1ns / 1ps

module pipt_mul #(
  parameter int W = 17
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   op_a,
  input  logic signed [W-1:0]   op_b,
  output logic signed [2*W-1:0] prod_r
);

  // Shared signed multiplier with its product registered.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[sim/crossing_checker.sv]
`timescale 1ns / 1ps

module crossing_checker #(
  parameter int MAX_EDGES  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_tvalid,
  input  logic                                    cfg_tready,
  input  logic [pipt_pkg::CFG_W-1:0]              cfg_tdata,
  input  logic                                    in_tvalid,
  input  logic                                    in_tready,
  // edge_index, start_x, start_y, end_x, end_y, point_x, point_y, zero pad
  input  logic [((pipt_pkg::INDEX_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // operation
  input  logic                                    in_tuser,
  input  logic                                    out_tvalid,
  input  logic                                    out_tready,
  // inside_res, crossing_count, zero pad
  input  logic [pipt_pkg::OUT_W-1:0]              out_tdata,
  output int                                      pending,
  output int                                      errors
);

  import pipt_pkg::*;

  localparam int CW = COORD_BITS;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } edge_t;

  typedef struct {
    logic               in_poly;
    logic [COUNT_W-1:0] crossings;
  } verdict_t;

  edge_t       edge_mem [MAX_EDGES];
  int unsigned edges_in_use;
  verdict_t    verdict_q [$];
  int          mismatch_cnt;

  // One edge counts when it straddles the point's y and the rightward ray meets it.
  function automatic bit ray_hits(edge_t e, longint px, longint py);
    longint sx = longint'(e.sx);
    longint sy = longint'(e.sy);
    longint ex = longint'(e.ex);
    longint ey = longint'(e.ey);
    longint dy;
    longint lhs;
    longint rhs;
    bit     straddle;
    straddle = (sy >= py && ey < py) || (sy < py && ey >= py);
    if (!straddle) return 1'b0;
    if (sx >= px && ex >= px) return 1'b1;
    // Intercept at or right of the point, compared without division.
    dy  = ey - sy;
    lhs = (py - sy) * (ex - sx);
    rhs = (px - sx) * dy;
    return (dy > 0) ? (lhs >= rhs) : (lhs <= rhs);
  endfunction

  function automatic verdict_t count_crossings(coord_t px, coord_t py);
    int unsigned hits = 0;
    int unsigned walk;
    verdict_t    v;
    walk = (edges_in_use < MAX_EDGES) ? edges_in_use : MAX_EDGES;
    for (int i = 0; i < walk; i++) begin
      if (ray_hits(edge_mem[i], longint'(px), longint'(py))) hits++;
    end
    v.in_poly   = hits[0];
    v.crossings = hits[COUNT_W-1:0];
    return v;
  endfunction

  // Follow the channels beat by beat; all values are sampled before the edge updates.
  always @(posedge clk) begin
    verdict_t want;
    int unsigned slot;
    if (!rst_n) begin
      edges_in_use = 0;
      verdict_q.delete();
    end else begin
      // Check a result beat against the oldest expectation.
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got inside %0d count %0d",
                   $time, out_tdata[0], out_tdata[COUNT_W:1]);
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.in_poly) begin
            $display("%0t: inside_res mismatch: expected %0d, got %0d",
                     $time, want.in_poly, out_tdata[0]);
            mismatch_cnt++;
          end
          if (out_tdata[COUNT_W:1] !== want.crossings) begin
            $display("%0t: crossing_count mismatch: expected %0d, got %0d",
                     $time, want.crossings, out_tdata[COUNT_W:1]);
            mismatch_cnt++;
          end
        end
      end

      // Loads update the edge store, queries queue their expected verdict.
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_LOAD) begin
          slot = 32'(in_tdata[INDEX_W-1:0]);
          if (slot < MAX_EDGES) begin
            edge_mem[slot].sx = in_tdata[INDEX_W + 0*CW +: CW];
            edge_mem[slot].sy = in_tdata[INDEX_W + 1*CW +: CW];
            edge_mem[slot].ex = in_tdata[INDEX_W + 2*CW +: CW];
            edge_mem[slot].ey = in_tdata[INDEX_W + 3*CW +: CW];
          end
        end else begin
          verdict_q.insert(verdict_q.size(),
                           count_crossings(in_tdata[INDEX_W + 4*CW +: CW],
                                           in_tdata[INDEX_W + 5*CW +: CW]));
        end
      end

      // A new edge count applies from the next query beat on.
      if (cfg_tvalid && cfg_tready) edges_in_use = 32'(cfg_tdata[COUNT_W-1:0]);
    end
    pending <= verdict_q.size();
    errors  <= mismatch_cnt;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  import pipt_pkg::*;

  localparam int MAX_EDGES    = 32;
  localparam int CW           = 16;
  localparam int DW           = ((INDEX_W + 6*CW + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 2*MAX_EDGES + 8;
  localparam int TARGET_ITEMS = 950;

  typedef logic signed [CW-1:0] coord_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_tvalid = 1'b0;
  logic              cfg_tready;
  logic [CFG_W-1:0]  cfg_tdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DW-1:0]     in_tdata = '0;
  logic              in_tuser = OP_LOAD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  int pending;
  int fail_count;

  int unsigned burst_left = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned settings_used = 0;

  // Polygon vertices of the current phase.
  coord_t vx [MAX_EDGES];
  coord_t vy [MAX_EDGES];

  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_in_polygon_test_core #(
    .MAX_EDGES (MAX_EDGES),
    .COORD_BITS(CW)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  crossing_checker #(
    .MAX_EDGES (MAX_EDGES),
    .COORD_BITS(CW)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .pending   (pending),
    .errors    (fail_count)
  );

  // Result side: out_tready follows one of four stall modes, redrawn when each one runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= stall_left[2];
    endcase
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t sat_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic logic [DW-1:0] pack_beat(logic [INDEX_W-1:0] idx, coord_t sx,
                                              coord_t sy, coord_t ex, coord_t ey,
                                              coord_t px, coord_t py);
    logic [DW-1:0] d = '0;
    d[INDEX_W-1:0]          = idx;
    d[INDEX_W + 0*CW +: CW] = sx;
    d[INDEX_W + 1*CW +: CW] = sy;
    d[INDEX_W + 2*CW +: CW] = ex;
    d[INDEX_W + 3*CW +: CW] = ey;
    d[INDEX_W + 4*CW +: CW] = px;
    d[INDEX_W + 5*CW +: CW] = py;
    return d;
  endfunction

  // Input side: bursts of random length separated by random gaps.
  task automatic send_beat(logic op, logic [DW-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 :
            $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Unused point fields of a load carry random bits.
  task automatic load_edge(int unsigned idx, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    send_beat(OP_LOAD, pack_beat(INDEX_W'(idx), sx, sy, ex, ey, rand_coord(), rand_coord()));
    loads_sent++;
  endtask

  // Unused edge fields of a query carry random bits.
  task automatic query_point(coord_t px, coord_t py);
    send_beat(OP_QUERY, pack_beat(INDEX_W'($urandom), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), px, py));
    queries_sent++;
  endtask

  // Drop valid, wait for every expected result, then let a trailing load settle.
  task automatic drain_all();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_edge_count(int unsigned n);
    drain_all();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= CFG_W'(n);
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    settings_used++;
  endtask

  // Closed loop of n vertices scattered around a center.
  task automatic make_polygon(int unsigned n, int unsigned shape);
    longint cx;
    longint cy;
    longint r;
    longint q;
    cx = (shape == 2) ? 0 : longint'($urandom_range(0, 40000)) - 20000;
    cy = (shape == 2) ? 0 : longint'($urandom_range(0, 40000)) - 20000;
    r  = (shape == 2) ? 40000 : longint'($urandom_range(1, 2000));
    q  = ($urandom_range(0, 1) == 0) ? 16 : 1;
    for (int i = 0; i < n; i++) begin
      vx[i] = sat_coord(cx + ((longint'($urandom_range(0, 32'(2*r))) - r) / q) * q);
      vy[i] = sat_coord(cy + ((longint'($urandom_range(0, 32'(2*r))) - r) / q) * q);
    end
  endtask

  // Query points biased toward vertices, vertex heights and edge midpoints.
  task automatic probe_polygon(int unsigned n);
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    longint lo_x;
    longint hi_x;
    longint lo_y;
    longint hi_y;
    pick = $urandom_range(0, 19);
    if (n == 0 || pick < 2) begin
      query_point(rand_coord(), rand_coord());
    end else begin
      a = $urandom_range(0, n - 1);
      b = (a + 1) % n;
      lo_x = longint'((vx[a] < vx[b]) ? vx[a] : vx[b]);
      hi_x = longint'((vx[a] < vx[b]) ? vx[b] : vx[a]);
      lo_y = longint'((vy[a] < vy[b]) ? vy[a] : vy[b]);
      hi_y = longint'((vy[a] < vy[b]) ? vy[b] : vy[a]);
      if (pick < 5) query_point(vx[a], vy[a]);
      else if (pick < 8) query_point(sat_coord(lo_x - 100 + $urandom_range(0, 200)), vy[a]);
      else if (pick < 11)
        query_point(sat_coord((longint'(vx[a]) + vx[b]) / 2),
                    sat_coord((longint'(vy[a]) + vy[b]) / 2));
      else
        query_point(sat_coord(lo_x - 200 + $urandom_range(0, 32'(hi_x - lo_x + 400))),
                    sat_coord(lo_y - 200 + $urandom_range(0, 32'(hi_y - lo_y + 400))));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned shape;
    int unsigned rounds;
    int unsigned phase_no;
    phase_no = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. At reset no edge is walked, so the count must be zero.
    query_point(coord_t'(32767), coord_t'(-32768));

    // Diamond with rising and falling slanted edges.
    set_edge_count(4);
    vx[0] = coord_t'(0);    vy[0] = coord_t'(-200);
    vx[1] = coord_t'(300);  vy[1] = coord_t'(0);
    vx[2] = coord_t'(0);    vy[2] = coord_t'(250);
    vx[3] = coord_t'(-250); vy[3] = coord_t'(0);
    for (int i = 0; i < 4; i++) load_edge(i, vx[i], vy[i], vx[(i + 1) % 4], vy[(i + 1) % 4]);
    load_edge(31, coord_t'(-32768), coord_t'(32767), coord_t'(32767), coord_t'(-32768));
    load_edge(4, coord_t'(-32768), coord_t'(-32768), coord_t'(32767), coord_t'(32767));
    query_point(coord_t'(0), coord_t'(0));
    // Exactly on a slanted edge, then one step to either side.
    query_point(coord_t'(150), coord_t'(-100));
    query_point(coord_t'(149), coord_t'(-100));
    query_point(coord_t'(151), coord_t'(-100));
    // Vertices: the upper end of an edge counts, the lower does not.
    query_point(coord_t'(0), coord_t'(250));
    query_point(coord_t'(0), coord_t'(-200));
    query_point(coord_t'(300), coord_t'(0));
    query_point(coord_t'(-250), coord_t'(0));
    query_point(coord_t'(-32768), coord_t'(0));
    query_point(coord_t'(32767), coord_t'(0));

    // Full-range diagonal edge gives the largest products.
    set_edge_count(5);
    query_point(coord_t'(-32768), coord_t'(-32768));
    query_point(coord_t'(32767), coord_t'(32767));
    query_point(coord_t'(0), coord_t'(0));
    query_point(coord_t'(-32768), coord_t'(32767));

    // Random phases: a fresh polygon per edge count, then queries around it.
    while (loads_sent + queries_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(3, 8);
        6: n = $urandom_range(0, 2);
        7: n = MAX_EDGES;
        default: n = $urandom_range(9, MAX_EDGES - 1);
      endcase
      if (phase_no == 1) n = MAX_EDGES;
      set_edge_count(n);
      shape = $urandom_range(0, 3);
      make_polygon(n, shape);
      // Every slot the query walks is loaded before the first query.
      for (int i = 0; i < n; i++) begin
        if (shape == 3 || $urandom_range(0, 9) == 0)
          load_edge(i, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        else
          load_edge(i, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
      end
      rounds = $urandom_range(4, 14);
      for (int k = 0; k < rounds; k++) begin
        // Stray loads overwrite slots with noise between queries.
        if ($urandom_range(0, 6) == 0)
          load_edge($urandom_range(0, MAX_EDGES - 1), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
        probe_polygon(n);
        // Sender holds off until all results are back.
        if (k == rounds / 2 && (phase_no == 0 || $urandom_range(0, 3) == 0)) drain_all();
      end
      phase_no++;
    end

    drain_all();
    $display("Covered %0d edge loads and %0d point queries over %0d edge-count settings,",
             loads_sent, queries_sent, settings_used);
    $display("from an empty walk up to all %0d edges, with vertex, on-edge and extreme points.",
             MAX_EDGES);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
